// ----- hw/rtl/jsu_pkg.sv -----
// Package: character codes, result word type and decode helpers for the JSON unescaper.
`timescale 1ns / 1ps
package jsu_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;

    localparam int unsigned MAX_RES    = 3;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       eos;
    } t_res;

    typedef struct packed {
        logic       ok;
        logic [7:0] chr;
    } t_esc;

    function automatic t_esc simple_escape(input logic [7:0] c);
        t_esc r;
        r.ok  = 1'b1;
        r.chr = c;
        unique case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: r.chr = c;
            CH_B:    r.chr = 8'h08;
            CH_F:    r.chr = 8'h0C;
            CH_N:    r.chr = 8'h0A;
            CH_R:    r.chr = 8'h0D;
            CH_T:    r.chr = 8'h09;
            default: begin
                r.ok  = 1'b0;
                r.chr = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            d = c - CH_LOW_A + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

// ----- hw/rtl/json_string_unescape.sv -----
// Top level: JSON string escape decoder, one raw character per word.
//
// Input stream (s_axis): one raw character per word in tdata, tlast on the
// final character of a string. Output stream (m_axis): one unescaped
// character per word in tdata, tuser = has_byte (0 only on a bare end
// marker), tlast on the last word given for the string.
// Each input word gives zero to three output words; the final one always
// gives at least one. Simple escapes, \uXXXX (low byte of the hex value)
// and short escapes cut off by the end of the string are decoded.
// An accepted word is held in the input register, then in the result queue.
// Throughput: one input word per cycle while each word gives at most one
// result and the receiver is ready; a word that gives two or three results
// holds the input side while the 4-entry result queue drains. The decode stage
// fires only when the queue holds at most one word.
// Reset (synchronous, active low) empties the input register and result
// queue and returns the decoder to normal mode.
// When the receiver stalls, the queue fills and tready on the input drops;
// no word is lost or repeated.
`timescale 1ns / 1ps
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // is_final
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] has_byte
    output logic       o_m_axis_tlast    // end_of_string
);

    typedef enum logic [2:0] {
        ST_NORMAL = 3'b001,
        ST_ESC    = 3'b010,
        ST_HEX    = 3'b100
    } t_mode;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // decoder state
    t_mode      r_mode, n_mode;
    logic [1:0] r_hcnt, n_hcnt;
    logic [7:0] r_hlb, n_hlb;
    logic [7:0] r_pend0, n_pend0;
    logic [7:0] r_pend1, n_pend1;

    // result queue
    t_res             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    t_res       res [MAX_RES];
    logic [1:0] res_n;
    logic       fire;
    logic       pop;
    t_esc       se_c, se_p1;
    logic [7:0] hlb_next;

    assign fire            = r_in_valid && (r_cnt <= CNT_W'(1));
    assign o_s_axis_tready = !r_in_valid || fire;
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = r_mem[r_rd].out_byte;
    assign o_m_axis_tuser  = r_mem[r_rd].has_byte;
    assign o_m_axis_tlast  = r_mem[r_rd].eos;

    assign se_c     = simple_escape(r_in_byte);
    assign se_p1    = simple_escape(r_pend1);
    assign hlb_next = {r_hlb[3:0], hex_value(r_in_byte)};

    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '0;
        end
        res_n   = 2'd0;
        n_mode  = r_mode;
        n_hcnt  = r_hcnt;
        n_hlb   = r_hlb;
        n_pend0 = r_pend0;
        n_pend1 = r_pend1;

        unique case (r_mode)
            ST_ESC: begin
                if (r_in_byte == CH_U && !r_in_last) begin
                    n_mode = ST_HEX;
                    n_hcnt = 2'd0;
                    n_hlb  = 8'h00;
                end else begin
                    if (se_c.ok) begin
                        res[res_n] = '{out_byte: se_c.chr, has_byte: 1'b1, eos: 1'b0};
                        res_n      = res_n + 2'd1;
                    end
                    n_mode = ST_NORMAL;
                end
            end
            ST_HEX: begin
                if (r_hcnt == 2'd3) begin
                    res[res_n] = '{out_byte: hlb_next, has_byte: 1'b1, eos: 1'b0};
                    res_n      = res_n + 2'd1;
                    n_mode     = ST_NORMAL;
                    n_hcnt     = 2'd0;
                    n_hlb      = 8'h00;
                end else if (r_in_last) begin
                    // string cut short: rerun buffered chars with normal rules
                    if (r_hcnt == 2'd1 && r_pend0 == CH_BSLASH) begin
                        if (se_c.ok) begin
                            res[res_n] = '{out_byte: se_c.chr, has_byte: 1'b1, eos: 1'b0};
                            res_n      = res_n + 2'd1;
                        end
                    end else if (r_hcnt == 2'd2 && r_pend0 == CH_BSLASH) begin
                        if (se_p1.ok) begin
                            res[res_n] = '{out_byte: se_p1.chr, has_byte: 1'b1, eos: 1'b0};
                            res_n      = res_n + 2'd1;
                        end
                        res[res_n] = '{out_byte: r_in_byte, has_byte: 1'b1, eos: 1'b0};
                        res_n      = res_n + 2'd1;
                    end else begin
                        if (r_hcnt != 2'd0) begin
                            res[res_n] = '{out_byte: r_pend0, has_byte: 1'b1, eos: 1'b0};
                            res_n      = res_n + 2'd1;
                        end
                        if (r_hcnt == 2'd2 && r_pend1 == CH_BSLASH) begin
                            if (se_c.ok) begin
                                res[res_n] = '{out_byte: se_c.chr, has_byte: 1'b1,
                                               eos: 1'b0};
                                res_n      = res_n + 2'd1;
                            end
                        end else begin
                            if (r_hcnt == 2'd2) begin
                                res[res_n] = '{out_byte: r_pend1, has_byte: 1'b1,
                                               eos: 1'b0};
                                res_n      = res_n + 2'd1;
                            end
                            res[res_n] = '{out_byte: r_in_byte, has_byte: 1'b1, eos: 1'b0};
                            res_n      = res_n + 2'd1;
                        end
                    end
                end else begin
                    if (r_hcnt == 2'd0) begin
                        n_pend0 = r_in_byte;
                    end
                    if (r_hcnt == 2'd1) begin
                        n_pend1 = r_in_byte;
                    end
                    n_hlb  = hlb_next;
                    n_hcnt = r_hcnt + 2'd1;
                end
            end
            default: begin
                if (r_in_byte == CH_BSLASH && !r_in_last) begin
                    n_mode = ST_ESC;
                end else begin
                    n_mode     = ST_NORMAL;
                    res[res_n] = '{out_byte: r_in_byte, has_byte: 1'b1, eos: 1'b0};
                    res_n      = res_n + 2'd1;
                end
            end
        endcase

        if (r_in_last) begin
            n_mode = ST_NORMAL;
            n_hcnt = 2'd0;
            n_hlb  = 8'h00;
            if (res_n == 2'd0) begin
                res[0] = '{out_byte: 8'h00, has_byte: 1'b0, eos: 1'b1};
                res_n  = 2'd1;
            end else begin
                res[res_n - 2'd1].eos = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_NORMAL;
            r_hcnt <= 2'd0;
            r_hlb  <= 8'h00;
        end else if (fire) begin
            r_mode <= n_mode;
            r_hcnt <= n_hcnt;
            r_hlb  <= n_hlb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pend0 <= n_pend0;
            r_pend1 <= n_pend1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < res_n) begin
                    r_mem[r_wr + PTR_W'(k)] <= res[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (fire) begin
                r_wr <= r_wr + PTR_W'(res_n);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + (fire ? CNT_W'(res_n) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

endmodule

// ----- hw/rtl/jsu_checker.sv -----
// Checker: port-level properties of the JSON unescaper, bound to the top level.
`timescale 1ns / 1ps
module jsu_checker
    import jsu_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    t_res w_out;
    assign w_out = '{out_byte: o_m_axis_tdata, has_byte: o_m_axis_tuser, eos: o_m_axis_tlast};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(w_out))
        else $error("output word changed while stalled");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("bare marker without end of string");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 8'h00)
        else $error("bare marker carries data");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked while result queue empty");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);
